### rtl/xed_pkg.sv
// shared types, character codes and command/status structs for the entity decoder
package xed_pkg;

  // default longest span from ampersand to semicolon
  localparam int MAX_SPAN_DEF = 10;

  // special characters
  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_LT   = 8'h3C;
  localparam logic [7:0] CH_GT   = 8'h3E;
  localparam logic [7:0] CH_QUOT = 8'h22;
  localparam logic [7:0] CH_APOS = 8'h27;

  // entity names, first byte in the high bits
  localparam logic [15:0] NAME_LT   = 16'h6C74;
  localparam logic [15:0] NAME_GT   = 16'h6774;
  localparam logic [23:0] NAME_AMP  = 24'h616D70;
  localparam logic [31:0] NAME_QUOT = 32'h71756F74;
  localparam logic [31:0] NAME_APOS = 32'h61706F73;

  // what one byte does to the entity state
  typedef enum logic [2:0] {
    EV_EMIT,
    EV_OPEN,
    EV_KNOWN,
    EV_UNKNOWN,
    EV_HOLD,
    EV_OVER
  } take_ev_t;

  // datapath operations
  typedef enum logic [1:0] {
    OP_NONE,
    OP_TAKE,
    OP_DUMP,
    OP_RELEASE
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   src_replay;
    logic   fin;
  } dp_cmd_t;

  typedef struct packed {
    take_ev_t ev;
    logic     rep_last;
    logic     dump_end;
    logic     hold_empty;
    logic     out_free;
    logic     pending;
  } dp_stat_t;

endpackage

### rtl/xed_if.sv
// stream interfaces for the text input and the decoded output

interface xed_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface xed_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

### rtl/xml_entity_decoder_core.sv
// top level of the xml entity decoder: controller, datapath and checks
// output: a byte appears in the output register in the cycle after its transaction
// throughput: one byte per cycle while the output register is free; an unknown name emits
// the ampersand, its held bytes and the semicolon, a span overrun replays MAX_ENTITY_SPAN
// bytes (held bytes plus the new one), and end of text releases and replays each open entity
// reset: synchronous, clears the entity state and the output valid; held bytes are not cleared
module xml_entity_decoder_core #(
  parameter int MAX_ENTITY_SPAN = xed_pkg::MAX_SPAN_DEF
) (
  input logic      clk,
  input logic      rst,
  xed_in_if.sink   text,
  xed_out_if.source decoded
);
  import xed_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // control
  xed_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (text.valid),
    .in_last  (text.in_last),
    .in_ready (text.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath
  xed_dp #(
    .MAX_ENTITY_SPAN (MAX_ENTITY_SPAN)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_byte   (text.in_byte),
    .out_ready (decoded.ready),
    .out_valid (decoded.valid),
    .out_byte  (decoded.out_byte),
    .out_last  (decoded.out_last)
  );

  // no datapath work while the output register is blocked
  a_no_work_when_blocked: assert property (@(posedge clk) disable iff (rst)
    !stat.out_free |-> cmd.op == OP_NONE)
    else $error("datapath command issued while output blocked");

  // an input transaction is always consumed by a take of the input byte
  a_accept_is_take: assert property (@(posedge clk) disable iff (rst)
    text.valid && text.ready |-> cmd.op == OP_TAKE && !cmd.src_replay)
    else $error("input transaction without a take");

  // the final byte of a text leaves no entity open
  a_final_closes: assert property (@(posedge clk) disable iff (rst)
    cmd.op != OP_NONE && cmd.fin |=> !stat.pending)
    else $error("entity still pending after final byte");

endmodule

### rtl/xed_dp.sv
// entity decoder datapath: hold buffer, name match, replay index and output register
module xed_dp #(
  parameter int MAX_ENTITY_SPAN = xed_pkg::MAX_SPAN_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  xed_pkg::dp_cmd_t cmd,
  output xed_pkg::dp_stat_t stat,
  input  logic [7:0]       in_byte,
  input  logic             out_ready,
  output logic             out_valid,
  output logic [7:0]       out_byte,
  output logic             out_last
);
  import xed_pkg::*;

  localparam int CW = $clog2(MAX_ENTITY_SPAN + 1);
  localparam int IW = $clog2(MAX_ENTITY_SPAN);
  localparam logic [CW-1:0] HOLD_MAX = CW'(MAX_ENTITY_SPAN - 1);
  localparam logic [CW-1:0] SPAN     = CW'(MAX_ENTITY_SPAN);
  localparam logic [IW-1:0] TAIL_IDX = IW'(MAX_ENTITY_SPAN - 1);

  logic [7:0]    hold [MAX_ENTITY_SPAN];
  logic [CW-1:0] hcnt;
  logic [CW-1:0] idx;
  logic [CW-1:0] rlen;
  logic          pending;

  logic [7:0]    rd_byte;
  logic [7:0]    cur;
  logic          known;
  logic [7:0]    known_ch;
  take_ev_t      ev;
  logic          dump_end;
  logic          emit_en;
  logic [7:0]    emit_byte;

  // one read port on the hold buffer, shared by replay and dump
  assign rd_byte = hold[idx[IW-1:0]];
  assign cur     = cmd.src_replay ? rd_byte : in_byte;

  // match held name against the five entities
  always_comb begin
    known    = 1'b1;
    known_ch = CH_AMP;
    if (hcnt == CW'(2) && {hold[0], hold[1]} == NAME_LT) begin
      known_ch = CH_LT;
    end else if (hcnt == CW'(2) && {hold[0], hold[1]} == NAME_GT) begin
      known_ch = CH_GT;
    end else if (hcnt == CW'(3) && {hold[0], hold[1], hold[2]} == NAME_AMP) begin
      known_ch = CH_AMP;
    end else if (hcnt == CW'(4) && {hold[0], hold[1], hold[2], hold[3]} == NAME_QUOT) begin
      known_ch = CH_QUOT;
    end else if (hcnt == CW'(4) && {hold[0], hold[1], hold[2], hold[3]} == NAME_APOS) begin
      known_ch = CH_APOS;
    end else begin
      known = 1'b0;
    end
  end

  // classify the current byte
  always_comb begin
    if (!pending) begin
      ev = (cur == CH_AMP) ? EV_OPEN : EV_EMIT;
    end else if (cur == CH_SEMI) begin
      ev = known ? EV_KNOWN : EV_UNKNOWN;
    end else if (hcnt < HOLD_MAX) begin
      ev = EV_HOLD;
    end else begin
      ev = EV_OVER;
    end
  end

  assign dump_end = (idx == hcnt);

  // byte sent to the output register this cycle
  always_comb begin
    emit_en   = 1'b0;
    emit_byte = cur;
    case (cmd.op)
      OP_TAKE: begin
        case (ev)
          EV_EMIT: begin
            emit_en = 1'b1;
          end
          EV_KNOWN: begin
            emit_en   = 1'b1;
            emit_byte = known_ch;
          end
          EV_UNKNOWN, EV_OVER: begin
            emit_en   = 1'b1;
            emit_byte = CH_AMP;
          end
          default: ;
        endcase
      end
      OP_DUMP: begin
        emit_en   = 1'b1;
        emit_byte = dump_end ? CH_SEMI : rd_byte;
      end
      OP_RELEASE: begin
        emit_en   = 1'b1;
        emit_byte = CH_AMP;
      end
      default: ;
    endcase
  end

  // entity control state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= 1'b0;
      hcnt      <= '0;
      idx       <= '0;
      rlen      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit_en) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (cmd.op)
        OP_TAKE: begin
          if (cmd.src_replay) begin
            idx <= idx + CW'(1);
          end
          case (ev)
            EV_OPEN: begin
              pending <= 1'b1;
              hcnt    <= '0;
            end
            EV_KNOWN: begin
              pending <= 1'b0;
              hcnt    <= '0;
            end
            EV_UNKNOWN: begin
              idx <= '0;
            end
            EV_HOLD: begin
              hcnt <= hcnt + CW'(1);
            end
            EV_OVER: begin
              pending <= 1'b0;
              hcnt    <= '0;
              idx     <= '0;
              rlen    <= SPAN;
            end
            default: ;
          endcase
        end
        OP_DUMP: begin
          if (dump_end) begin
            pending <= 1'b0;
            hcnt    <= '0;
          end else begin
            idx <= idx + CW'(1);
          end
        end
        OP_RELEASE: begin
          pending <= 1'b0;
          hcnt    <= '0;
          idx     <= '0;
          rlen    <= hcnt;
        end
        default: ;
      endcase
    end
  end

  // payload: held name bytes and output byte
  always_ff @(posedge clk) begin
    if (emit_en) begin
      out_byte <= emit_byte;
      out_last <= cmd.fin;
    end
    if (cmd.op == OP_TAKE && ev == EV_HOLD) begin
      hold[hcnt[IW-1:0]] <= cur;
    end else if (cmd.op == OP_TAKE && ev == EV_OVER) begin
      hold[TAIL_IDX] <= cur;
    end
  end

  // status to the controller
  assign stat.ev         = ev;
  assign stat.rep_last   = ((idx + CW'(1)) == rlen);
  assign stat.dump_end   = dump_end;
  assign stat.hold_empty = (hcnt == '0);
  assign stat.out_free   = !out_valid || out_ready;
  assign stat.pending    = pending;

endmodule

### rtl/xed_ctrl.sv
// entity decoder controller: sequences input, replay, verbatim dump and end-of-text release
module xed_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_last,
  output logic              in_ready,
  input  xed_pkg::dp_stat_t stat,
  output xed_pkg::dp_cmd_t  cmd
);
  import xed_pkg::*;

  typedef enum logic [3:0] {
    S_RUN     = 4'b0001,
    S_REPLAY  = 4'b0010,
    S_DUMP    = 4'b0100,
    S_RELEASE = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;
  logic   lm;
  logic   lm_next;
  logic   single_out;

  // events that emit exactly one byte and leave nothing pending
  assign single_out = (stat.ev == EV_EMIT) || (stat.ev == EV_KNOWN);

  // next state and datapath command
  always_comb begin
    state_next     = state;
    lm_next        = lm;
    in_ready       = 1'b0;
    cmd.op         = OP_NONE;
    cmd.src_replay = 1'b0;
    cmd.fin        = 1'b0;
    unique case (state)
      S_RUN: begin
        in_ready = stat.out_free;
        if (in_valid && stat.out_free) begin
          cmd.op  = OP_TAKE;
          cmd.fin = in_last && single_out;
          lm_next = in_last;
          case (stat.ev) inside
            EV_UNKNOWN:      state_next = S_DUMP;
            EV_OVER:         state_next = S_REPLAY;
            EV_OPEN, EV_HOLD: state_next = in_last ? S_RELEASE : S_RUN;
            default:         state_next = S_RUN;
          endcase
        end
      end
      S_REPLAY: begin
        cmd.src_replay = 1'b1;
        if (stat.out_free) begin
          cmd.op  = OP_TAKE;
          cmd.fin = lm && stat.rep_last && single_out;
          case (stat.ev) inside
            EV_UNKNOWN: state_next = S_DUMP;
            EV_OVER:    state_next = S_REPLAY;
            EV_OPEN, EV_HOLD: begin
              if (stat.rep_last) begin
                state_next = lm ? S_RELEASE : S_RUN;
              end
            end
            default: begin
              if (stat.rep_last) begin
                state_next = S_RUN;
              end
            end
          endcase
        end
      end
      S_DUMP: begin
        cmd.src_replay = 1'b1;
        if (stat.out_free) begin
          cmd.op  = OP_DUMP;
          cmd.fin = lm && stat.dump_end;
          if (stat.dump_end) begin
            state_next = S_RUN;
          end
        end
      end
      S_RELEASE: begin
        if (stat.out_free) begin
          cmd.op     = OP_RELEASE;
          cmd.fin    = stat.hold_empty;
          state_next = stat.hold_empty ? S_RUN : S_REPLAY;
        end
      end
      default: begin
        state_next = S_RUN;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RUN;
      lm    <= 1'b0;
    end else begin
      state <= state_next;
      lm    <= lm_next;
    end
  end

endmodule

### tb/sv/tb_xml_entity_decoder_core.sv
// self-checking testbench for the xml entity decoder core
`timescale 1ns / 100ps

module tb_xml_entity_decoder_core;
  import xed_pkg::*;

  localparam int SPAN         = MAX_SPAN_DEF;
  localparam int RESET_CYCLES = 10;
  localparam int ITEM_TARGET  = 460;
  localparam int HOLD_CYCLES  = 200;
  localparam int SETTLE       = 30;
  localparam int CYCLE_LIMIT  = 300000;

  // one expected decoded byte
  typedef struct packed {
    logic [7:0] chr;
    logic       eot;
  } decoded_t;

  // tracks the entity state of the text and checks every decoded byte
  class decoded_text_tracker;
    logic [7:0] held [SPAN];
    int         held_n = 0;
    bit         amp_open = 0;
    logic [7:0] replay_q [$];
    logic [7:0] step_bytes [$];
    decoded_t   awaited_q [$];
    int         errors = 0;

    function void emit(logic [7:0] b);
      if (step_bytes.size() < SPAN + 1) step_bytes = {step_bytes, b};
    endfunction

    // compare the held name with a packed name, first byte high
    function bit held_matches(logic [31:0] name, int len);
      if (held_n != len) return 0;
      for (int k = 0; k < len; k++)
        if (held[k] != name[8*(len-1-k) +: 8]) return 0;
      return 1;
    endfunction

    // give up on the open ampersand and replay its held bytes
    function void release_amp();
      emit(CH_AMP);
      for (int k = 0; k < held_n; k++) replay_q = {replay_q, held[k]};
      amp_open = 0;
      held_n = 0;
    endfunction

    // semicolon seen: known name or verbatim copy
    function void resolve();
      if (held_matches(32'(NAME_LT), 2)) emit(CH_LT);
      else if (held_matches(32'(NAME_GT), 2)) emit(CH_GT);
      else if (held_matches(32'(NAME_AMP), 3)) emit(CH_AMP);
      else if (held_matches(NAME_QUOT, 4)) emit(CH_QUOT);
      else if (held_matches(NAME_APOS, 4)) emit(CH_APOS);
      else begin
        emit(CH_AMP);
        for (int k = 0; k < held_n; k++) emit(held[k]);
        emit(CH_SEMI);
      end
      amp_open = 0;
      held_n = 0;
    endfunction

    function void take(logic [7:0] b);
      if (!amp_open) begin
        if (b == CH_AMP) begin
          amp_open = 1;
          held_n = 0;
        end else begin
          emit(b);
        end
        return;
      end
      if (b == CH_SEMI) begin
        resolve();
        return;
      end
      if (held_n < SPAN - 1) begin
        held[held_n] = b;
        held_n++;
        return;
      end
      // span overrun
      release_amp();
      replay_q = {replay_q, b};
    endfunction

    function void drain();
      while (replay_q.size() != 0) take(replay_q.pop_front());
    endfunction

    // note an accepted text transaction and queue the bytes it yields
    function void note_text(logic [7:0] b, logic last);
      decoded_t d;
      step_bytes.delete();
      replay_q = {replay_q, b};
      drain();
      if (last) begin
        while (amp_open) begin
          release_amp();
          drain();
        end
      end
      foreach (step_bytes[k]) begin
        d.chr = step_bytes[k];
        d.eot = last && (k == step_bytes.size() - 1);
        awaited_q = {awaited_q, d};
      end
    endfunction

    // check one decoded transaction against the oldest expectation
    function void check_decoded(logic [7:0] b, logic last);
      decoded_t want;
      if (awaited_q.size() == 0) begin
        $error("unexpected decoded byte: out_byte %h out_last %b", b, last);
        errors++;
        return;
      end
      want = awaited_q.pop_front();
      if (b !== want.chr) begin
        $error("out_byte mismatch: expected %h actual %h", want.chr, b);
        errors++;
      end
      if (last !== want.eot) begin
        $error("out_last mismatch: expected %b actual %b", want.eot, last);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  xed_in_if  text();
  xed_out_if decoded();

  decoded_text_tracker tracker;
  int cycles = 0;
  int bytes_sent = 0;
  int in_gap_max = 0;
  int out_gap_max = 0;
  bit hold_off_req = 0;

  xml_entity_decoder_core #(.MAX_ENTITY_SPAN(SPAN)) uut (
    .clk     (clk),
    .rst     (rst),
    .text    (text),
    .decoded (decoded)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // run time limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && decoded.valid === 1'b1 && decoded.ready === 1'b1)
      tracker.check_decoded(decoded.out_byte, decoded.out_last);
  end

  // receiver: random stalls and one long hold-off on request
  initial begin
    int stall;
    decoded.ready = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        decoded.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 0;
      end
      stall = $urandom_range(0, out_gap_max);
      if (stall > 0) begin
        decoded.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      decoded.ready <= 1'b1;
      do @(posedge clk); while (decoded.valid !== 1'b1);
    end
  end

  // offer one text byte after a random gap and wait for its transaction
  task automatic send_text(logic [7:0] b, logic last);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      text.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    text.valid   <= 1'b1;
    text.in_byte <= b;
    text.in_last <= last;
    do @(posedge clk); while (text.ready !== 1'b1);
    tracker.note_text(b, last);
    bytes_sent++;
  endtask

  task automatic send_str(string s, bit last_at_end);
    for (int i = 0; i < s.len(); i++)
      send_text(s[i], last_at_end && (i == s.len() - 1));
  endtask

  // end of text now and then
  function automatic logic text_ends_here();
    return $urandom_range(0, 29) == 0;
  endfunction

  function automatic logic [7:0] name_byte();
    logic [79:0] letters;
    letters = "lgtampquos";
    case ($urandom_range(0, 9))
      0, 1:    return 8'($urandom_range(0, 255));
      2:       return CH_AMP;
      default: return letters[8*$urandom_range(0, 9) +: 8];
    endcase
  endfunction

  task automatic pick_entity(output logic [31:0] name, output int len);
    case ($urandom_range(0, 4))
      0:       begin name = 32'(NAME_LT);  len = 2; end
      1:       begin name = 32'(NAME_GT);  len = 2; end
      2:       begin name = 32'(NAME_AMP); len = 3; end
      3:       begin name = NAME_QUOT;     len = 4; end
      default: begin name = NAME_APOS;     len = 4; end
    endcase
  endtask

  // one random piece of text, a well-formed entity in two of five cases
  task automatic send_fragment();
    int kind, len, cut, flip;
    logic [31:0] name;
    logic [7:0] b;
    kind = $urandom_range(0, 99);
    pick_entity(name, len);
    if (kind < 40) begin
      // known entity
      send_text(CH_AMP, 1'b0);
      for (int k = 0; k < len; k++) send_text(name[8*(len-1-k) +: 8], 1'b0);
      send_text(CH_SEMI, text_ends_here());
    end else if (kind < 55) begin
      // any byte
      send_text(8'($urandom_range(0, 255)), text_ends_here());
    end else if (kind < 65) begin
      // unknown or empty name
      send_text(CH_AMP, 1'b0);
      cut = $urandom_range(0, SPAN - 2);
      for (int k = 0; k < cut; k++) send_text(name_byte(), text_ends_here());
      send_text(CH_SEMI, text_ends_here());
    end else if (kind < 75) begin
      // name at the span limit or too long for the span
      send_text(CH_AMP, 1'b0);
      cut = $urandom_range(SPAN - 1, SPAN + 3);
      for (int k = 0; k < cut; k++) begin
        b = name_byte();
        if (b == CH_SEMI) b = "x";
        send_text(b, text_ends_here());
      end
      if ($urandom_range(0, 1)) send_text(CH_SEMI, text_ends_here());
    end else if (kind < 82) begin
      // entity cut short, no semicolon
      send_text(CH_AMP, text_ends_here());
      cut = $urandom_range(0, len);
      for (int k = 0; k < cut; k++)
        send_text(name[8*(len-1-k) +: 8], text_ends_here());
    end else if (kind < 90) begin
      // near miss: one byte of a known name altered
      flip = $urandom_range(0, len - 1);
      send_text(CH_AMP, 1'b0);
      for (int k = 0; k < len; k++) begin
        b = name[8*(len-1-k) +: 8];
        if (k == flip) b = b ^ (8'h01 << $urandom_range(0, 7));
        send_text(b, 1'b0);
      end
      send_text(CH_SEMI, text_ends_here());
    end else begin
      // plain printable run
      cut = $urandom_range(1, 6);
      for (int k = 0; k < cut; k++)
        send_text(8'($urandom_range(8'h20, 8'h7E)), text_ends_here());
    end
  endtask

  function automatic int pick_gap_max();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 7;
      default: return $urandom_range(1, 7);
    endcase
  endfunction

  // stop offering and wait until every expected byte has come out
  task automatic wait_for_decoded();
    text.valid <= 1'b0;
    @(posedge clk);
    while (tracker.awaited_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // main sequence
  initial begin
    int next_phase;
    bit hold_done, pause_done;
    tracker = new();
    rst = 1'b1;
    text.valid = 1'b0;
    text.in_byte = 8'h00;
    text.in_last = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // directed: byte extremes, empty name, nested ampersand,
    // span overrun with replay, open entity at end of text
    send_text(8'h00, 1'b0);
    send_text(8'hFF, 1'b0);
    send_str("&;", 1'b0);
    send_str("&a&t;", 1'b0);
    send_str("&amp;", 1'b0);
    send_str("&abcd&ltxyz;", 1'b0);
    send_str("&lt", 1'b1);

    // random text
    next_phase = bytes_sent;
    hold_done = 0;
    pause_done = 0;
    while (bytes_sent < ITEM_TARGET) begin
      if (bytes_sent >= next_phase) begin
        in_gap_max = pick_gap_max();
        out_gap_max = pick_gap_max();
        next_phase = bytes_sent + $urandom_range(30, 80);
      end
      if (!hold_done && bytes_sent >= 150) begin
        // receiver holds off while text keeps coming
        hold_off_req = 1;
        in_gap_max = 0;
        while (bytes_sent < 210) send_fragment();
        hold_done = 1;
      end
      if (!pause_done && bytes_sent >= 320) begin
        wait_for_decoded();
        pause_done = 1;
      end
      send_fragment();
    end
    send_text("Z", 1'b1);

    wait_for_decoded();
    if (tracker.errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
